>>> src/rm2q_pkg.sv
// Shared types, constants and the square root step for the matrix to quaternion unit.
package rm2q_pkg;

   localparam int IN_W            = 16;
   localparam int MAG_W           = 15;
   localparam int OUT_W           = 16;
   localparam int SUM_W           = 18;
   localparam int DIFF_W          = 17;
   localparam int REM_W           = 18;
   localparam int RAD_W           = 2 * MAG_W;
   localparam int FRAC_SHIFT      = RAD_W - IN_W;
   localparam int STEPS_PER_STAGE = 3;
   localparam int SQRT_STAGES     = MAG_W / STEPS_PER_STAGE;
   localparam int NUM_LANES       = 4;

   localparam logic signed [SUM_W-1:0] ONE_Q14 = SUM_W'(16384);
   localparam logic [MAG_W-1:0]        MAG_MAX = {MAG_W{1'b1}};

   // lane order inside a stage word
   localparam int LANE_W = 0;
   localparam int LANE_X = 1;
   localparam int LANE_Y = 2;
   localparam int LANE_Z = 3;

   // sign bit order: x, y, z
   localparam int SIGN_X = 0;
   localparam int SIGN_Y = 1;
   localparam int SIGN_Z = 2;

   typedef struct packed {
      logic             sat;
      logic [REM_W-1:0] rem;
      logic [MAG_W-1:0] root;
      logic [RAD_W-1:0] rad;
   } lane_type;

   typedef struct packed {
      logic [2:0]                   neg;
      lane_type [NUM_LANES-1:0]     lane;
   } stage_type;

   // One digit of the restoring square root: bring down two radicand bits, try root*4+1.
   function automatic lane_type sqrt_step(input lane_type cur);
      lane_type         nxt;
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      shifted  = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
      trial    = {1'b0, cur.root, 2'b01};
      nxt      = cur;
      nxt.rad  = {cur.rad[RAD_W-3:0], 2'b00};
      if (shifted >= trial) begin
         nxt.rem  = shifted - trial;
         nxt.root = {cur.root[MAG_W-2:0], 1'b1};
      end else begin
         nxt.rem  = shifted;
         nxt.root = {cur.root[MAG_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

>>> src/rm2q_req_if.sv
// Matrix input channel: valid/ready handshake with nine Q2.14 entries.
interface rm2q_req_if;
   import rm2q_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [IN_W-1:0]  r00;
   logic signed [IN_W-1:0]  r01;
   logic signed [IN_W-1:0]  r02;
   logic signed [IN_W-1:0]  r10;
   logic signed [IN_W-1:0]  r11;
   logic signed [IN_W-1:0]  r12;
   logic signed [IN_W-1:0]  r20;
   logic signed [IN_W-1:0]  r21;
   logic signed [IN_W-1:0]  r22;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   output ready);
endinterface

>>> src/rm2q_rsp_if.sv
// Quaternion result channel: valid/ready handshake with an unsigned Q0.15 w and three Q1.15 components.
interface rm2q_rsp_if;
   import rm2q_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [MAG_W-1:0]        quat_w;
   logic signed [OUT_W-1:0] quat_x;
   logic signed [OUT_W-1:0] quat_y;
   logic signed [OUT_W-1:0] quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

>>> src/rm2q_front.sv
// Front stage: diagonal sums, clamp and saturation flags, sign differences.
module rm2q_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              valid_in,
   input  logic signed [rm2q_pkg::IN_W-1:0]  r00,
   input  logic signed [rm2q_pkg::IN_W-1:0]  r01,
   input  logic signed [rm2q_pkg::IN_W-1:0]  r02,
   input  logic signed [rm2q_pkg::IN_W-1:0]  r10,
   input  logic signed [rm2q_pkg::IN_W-1:0]  r11,
   input  logic signed [rm2q_pkg::IN_W-1:0]  r12,
   input  logic signed [rm2q_pkg::IN_W-1:0]  r20,
   input  logic signed [rm2q_pkg::IN_W-1:0]  r21,
   input  logic signed [rm2q_pkg::IN_W-1:0]  r22,
   output logic                              valid_ff,
   output rm2q_pkg::stage_type               data_ff
);
   import rm2q_pkg::*;

   logic signed [SUM_W-1:0]  sum_w, sum_x, sum_y, sum_z;
   logic signed [DIFF_W-1:0] diff_x, diff_y, diff_z;
   stage_type                data_in;

   // Clamp a negative sum to zero; flag sums of 1.0*4 or more (root reaches 1.0).
   function automatic lane_type make_lane(input logic signed [SUM_W-1:0] s);
      lane_type l;
      l.sat  = !s[SUM_W-1] && s[IN_W];
      l.rem  = '0;
      l.root = '0;
      l.rad  = s[SUM_W-1] ? '0 : {s[IN_W-1:0], {FRAC_SHIFT{1'b0}}};
      return l;
   endfunction

   always_comb begin
      sum_w  = ONE_Q14 + SUM_W'(r00) + SUM_W'(r11) + SUM_W'(r22);
      sum_x  = ONE_Q14 + SUM_W'(r00) - SUM_W'(r11) - SUM_W'(r22);
      sum_y  = ONE_Q14 - SUM_W'(r00) + SUM_W'(r11) - SUM_W'(r22);
      sum_z  = ONE_Q14 - SUM_W'(r00) - SUM_W'(r11) + SUM_W'(r22);
      diff_x = DIFF_W'(r21) - DIFF_W'(r12);
      diff_y = DIFF_W'(r02) - DIFF_W'(r20);
      diff_z = DIFF_W'(r10) - DIFF_W'(r01);

      data_in.lane[LANE_W] = make_lane(sum_w);
      data_in.lane[LANE_X] = make_lane(sum_x);
      data_in.lane[LANE_Y] = make_lane(sum_y);
      data_in.lane[LANE_Z] = make_lane(sum_z);
      data_in.neg[SIGN_X]  = diff_x[DIFF_W-1];
      data_in.neg[SIGN_Y]  = diff_y[DIFF_W-1];
      data_in.neg[SIGN_Z]  = diff_z[DIFF_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> src/rm2q_sqrt_stage.sv
// One square root pipeline stage: a few root digits for all four lanes.
module rm2q_sqrt_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_prev,
   input  rm2q_pkg::stage_type  data_prev,
   output logic                 valid_ff,
   output rm2q_pkg::stage_type  data_ff
);
   import rm2q_pkg::*;

   stage_type data_in;

   always_comb begin
      data_in = data_prev;
      for (int lane = 0; lane < NUM_LANES; lane++) begin
         for (int step = 0; step < STEPS_PER_STAGE; step++) begin
            data_in.lane[lane] = sqrt_step(data_in.lane[lane]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

>>> src/rotation_matrix_to_quaternion_unit.sv
// Stages: 1 sum stage + 5 root stages from accepted matrix word to result word valid.
// Throughput: one matrix word per unstalled cycle; the root is a 15-digit restoring square root,
// 3 digits per stage, four lanes side by side; every stage takes a new word each unstalled cycle.
// Stall: the whole pipe holds while the output word waits; req ready = last stage empty or taken.
// Reset: synchronous, active high; clears all stage valid bits, data registers keep contents.
// No internal state survives between words.
module rotation_matrix_to_quaternion_unit (
   input  logic       clock,
   input  logic       reset,
   rm2q_req_if.sink   req_chan,
   rm2q_rsp_if.source rsp_chan
);
   import rm2q_pkg::*;

   // Stage 0 is the sum stage; stages 1..SQRT_STAGES do the root digits.
   logic [SQRT_STAGES:0] valid_vec;
   stage_type            stage_data [SQRT_STAGES+1];
   logic                 advance;
   stage_type            last;
   logic [MAG_W-1:0]     mag_w, mag_x, mag_y, mag_z;

   // Advance every stage together whenever the output register is free or being drained.
   assign advance        = !valid_vec[SQRT_STAGES] || rsp_chan.ready;
   assign req_chan.ready = advance;

   rm2q_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .valid_in (req_chan.valid),
      .r00      (req_chan.r00),
      .r01      (req_chan.r01),
      .r02      (req_chan.r02),
      .r10      (req_chan.r10),
      .r11      (req_chan.r11),
      .r12      (req_chan.r12),
      .r20      (req_chan.r20),
      .r21      (req_chan.r21),
      .r22      (req_chan.r22),
      .valid_ff (valid_vec[0]),
      .data_ff  (stage_data[0])
   );

   // Chain the root stages; each one brings down three radicand digit pairs.
   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_root
      rm2q_sqrt_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .valid_prev (valid_vec[g]),
         .data_prev  (stage_data[g]),
         .valid_ff   (valid_vec[g+1]),
         .data_ff    (stage_data[g+1])
      );
   end

   // The last root stage doubles as the output register; format the word from it.
   always_comb begin
      last  = stage_data[SQRT_STAGES];
      mag_w = last.lane[LANE_W].sat ? MAG_MAX : last.lane[LANE_W].root;
      mag_x = last.lane[LANE_X].sat ? MAG_MAX : last.lane[LANE_X].root;
      mag_y = last.lane[LANE_Y].sat ? MAG_MAX : last.lane[LANE_Y].root;
      mag_z = last.lane[LANE_Z].sat ? MAG_MAX : last.lane[LANE_Z].root;

      rsp_chan.valid  = valid_vec[SQRT_STAGES];
      rsp_chan.quat_w = mag_w;
      // Negate only on a strictly negative difference; zero keeps the positive sign.
      rsp_chan.quat_x = last.neg[SIGN_X] ? OUT_W'(-{1'b0, mag_x}) : {1'b0, mag_x};
      rsp_chan.quat_y = last.neg[SIGN_Y] ? OUT_W'(-{1'b0, mag_y}) : {1'b0, mag_y};
      rsp_chan.quat_z = last.neg[SIGN_Z] ? OUT_W'(-{1'b0, mag_z}) : {1'b0, mag_z};
   end

`ifndef SYNTH
   // A stalled pipe moves no word.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_vec))
      else $error("pipe valid bits changed during stall");

   // An accepted matrix lands in the sum stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_vec[0])
      else $error("accepted word lost at sum stage");

   // A word in the last stage that is taken leaves, unless a new one follows.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !valid_vec[SQRT_STAGES-1]) |=> !rsp_chan.valid)
      else $error("result word repeated");

   // Magnitudes stay within 32767, so a component never reads as -32768.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.quat_x != 16'h8000 && rsp_chan.quat_y != 16'h8000
                          && rsp_chan.quat_z != 16'h8000))
      else $error("component out of saturated range");
`endif

endmodule

>>> test/rm2q_checker.sv
// Checker for the matrix to quaternion unit: predicts each quaternion and compares results.
`timescale 1ns / 100ps

module rm2q_checker (
   input  logic clock,
   input  logic reset,
   rm2q_req_if  req_mon,
   rm2q_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_words
);
   import rm2q_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [MAG_W-1:0]        w;
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
   } quat_word_type;

   quat_word_type expected_quats[$];

   // Truncated integer square root, two radicand bits per step.
   function automatic logic [15:0] floor_sqrt(input logic [31:0] rad);
      logic [31:0] rest;
      logic [31:0] root;
      logic [31:0] probe;
      rest  = rad;
      root  = 32'd0;
      probe = 32'h4000_0000;
      while (probe > rest)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[15:0];
   endfunction

   // Clamp a negative sum to zero, take sqrt(sum * 2^14), saturate at full scale.
   function automatic logic [MAG_W-1:0] lane_magnitude(input int sum);
      logic [31:0] rad;
      logic [15:0] root;
      rad  = (sum < 0) ? 32'd0 : (32'(sum) << 14);
      root = floor_sqrt(rad);
      return (root > {1'b0, MAG_MAX}) ? MAG_MAX : root[MAG_W-1:0];
   endfunction

   function automatic logic signed [OUT_W-1:0] apply_sign(input logic [MAG_W-1:0] mag,
                                                          input int diff);
      logic [OUT_W-1:0] v;
      v = {1'b0, mag};
      return (diff < 0) ? OUT_W'(0 - v) : v;
   endfunction

   function automatic quat_word_type quat_of_matrix(input int a00, a01, a02,
                                                    input int a10, a11, a12,
                                                    input int a20, a21, a22);
      quat_word_type q;
      q.w = lane_magnitude(16384 + a00 + a11 + a22);
      q.x = apply_sign(lane_magnitude(16384 + a00 - a11 - a22), a21 - a12);
      q.y = apply_sign(lane_magnitude(16384 - a00 + a11 - a22), a02 - a20);
      q.z = apply_sign(lane_magnitude(16384 - a00 - a11 + a22), a10 - a01);
      return q;
   endfunction

   task automatic note_failure(input string what, input quat_word_type want,
                               input quat_word_type got);
      if (fail_count < REPORT_LIMIT)
         $display("%0t: %s: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                  $realtime, what, want.w, want.x, want.y, want.z,
                  got.w, got.x, got.y, got.z);
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin
      quat_word_type want;
      quat_word_type got;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.quat_w, rsp_mon.quat_x, rsp_mon.quat_y, rsp_mon.quat_z};
            if (expected_quats.size() == 0) begin
               note_failure("result word with none expected", '0, got);
            end else begin
               want = expected_quats.pop_front();
               if (got.w !== want.w || got.x !== want.x ||
                   got.y !== want.y || got.z !== want.z)
                  note_failure("quaternion mismatch", want, got);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_quats.push_back(quat_of_matrix(
               req_mon.r00, req_mon.r01, req_mon.r02,
               req_mon.r10, req_mon.r11, req_mon.r12,
               req_mon.r20, req_mon.r21, req_mon.r22));
         pending_words = expected_quats.size();
      end
   end

endmodule

>>> test/tb_top.sv
// Testbench top for the matrix to quaternion unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
   import rm2q_pkg::*;

   localparam int RANDOM_WORDS   = 650;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int PRESSURE_AFTER = 150;  // matrix words accepted before the long hold-off
   localparam int PRESSURE_HOLD  = 300;
   localparam logic signed [IN_W-1:0] ONE  = 16'sd16384;
   localparam logic signed [IN_W-1:0] MONE = -16'sd16384;
   localparam logic signed [IN_W-1:0] PMAX = 16'sh7FFF;
   localparam logic signed [IN_W-1:0] NMAX = 16'sh8000;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending_words;
   int   req_words = 0;

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rm2q_req_if req_chan_if ();
   rm2q_rsp_if rsp_chan_if ();

   rotation_matrix_to_quaternion_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan_if.sink),
      .rsp_chan (rsp_chan_if.source)
   );

   rm2q_checker quat_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan_if),
      .rsp_mon       (rsp_chan_if),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   // Count accepted matrix words; the receiver uses this to time its long hold-off.
   always @(posedge clock) begin
      if (!reset && req_chan_if.valid && req_chan_if.ready)
         req_words <= req_words + 1;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      else if (pick < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Offer one matrix word and hold it until accepted; return at the next falling edge.
   task automatic offer_matrix(input logic signed [IN_W-1:0] a00, a01, a02,
                               input logic signed [IN_W-1:0] a10, a11, a12,
                               input logic signed [IN_W-1:0] a20, a21, a22);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_chan_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan_if.valid <= 1'b1;
      req_chan_if.r00   <= a00;
      req_chan_if.r01   <= a01;
      req_chan_if.r02   <= a02;
      req_chan_if.r10   <= a10;
      req_chan_if.r11   <= a11;
      req_chan_if.r12   <= a12;
      req_chan_if.r20   <= a20;
      req_chan_if.r21   <= a21;
      req_chan_if.r22   <= a22;
      @(posedge clock);
      while (!req_chan_if.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Result side: random runs of ready and stalls, plus one long hold-off that lets
   // the pipe fill while the sender keeps offering words.
   initial begin : result_receiver
      int  hold_left;
      int  run_left;
      bit  pressure_done;
      hold_left         = 0;
      run_left          = 0;
      pressure_done     = 1'b0;
      rsp_chan_if.ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!pressure_done && req_words >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_HOLD;
            run_left      = 0;
         end
         if (hold_left == 0 && run_left == 0) begin
            // occasionally a long stretch with no stalls at all
            run_left  = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 20);
            hold_left = idle_gap();
         end
         if (hold_left > 0) begin
            rsp_chan_if.ready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_chan_if.ready <= 1'b1;
            run_left = run_left - 1;
         end
         @(negedge clock);
      end
   end

   // End the run if nothing moves on either channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan_if.valid && req_chan_if.ready) ||
             (rsp_chan_if.valid && rsp_chan_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
      end
      $display("rotation_matrix_to_quaternion_unit verification failed");
      $finish;
   end

   initial begin : stimulus
      logic signed [IN_W-1:0] e [0:8];
      int kind;
      int noise;
      int p0;
      int p1;
      int p2;
      int k;
      int n;

      // Drive every input to a known value before the first edge.
      reset             = 1'b1;
      req_chan_if.valid = 1'b0;
      req_chan_if.r00   = '0;
      req_chan_if.r01   = '0;
      req_chan_if.r02   = '0;
      req_chan_if.r10   = '0;
      req_chan_if.r11   = '0;
      req_chan_if.r12   = '0;
      req_chan_if.r20   = '0;
      req_chan_if.r21   = '0;
      req_chan_if.r22   = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Identity: w saturates at full scale, x/y/z zero with zero differences.
      offer_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
      // Half turns about x, y and z: one vector lane saturates, w is zero.
      offer_matrix(ONE, 0, 0, 0, MONE, 0, 0, 0, MONE);
      offer_matrix(MONE, 0, 0, 0, ONE, 0, 0, 0, MONE);
      offer_matrix(MONE, 0, 0, 0, MONE, 0, 0, 0, ONE);
      // Quarter turns about each axis, both directions.
      offer_matrix(ONE, 0, 0, 0, 0, MONE, 0, ONE, 0);
      offer_matrix(ONE, 0, 0, 0, 0, ONE, 0, MONE, 0);
      offer_matrix(0, 0, ONE, 0, ONE, 0, MONE, 0, 0);
      offer_matrix(0, 0, MONE, 0, ONE, 0, ONE, 0, 0);
      offer_matrix(0, MONE, 0, ONE, 0, 0, 0, 0, ONE);
      offer_matrix(0, ONE, 0, MONE, 0, 0, 0, 0, ONE);
      // All zero, all most negative, all most positive.
      offer_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
      offer_matrix(NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX);
      offer_matrix(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX);
      // Largest sums in each lane, with the widest differences of both signs.
      offer_matrix(PMAX, NMAX, PMAX, PMAX, NMAX, PMAX, NMAX, NMAX, NMAX);
      offer_matrix(NMAX, PMAX, NMAX, NMAX, PMAX, NMAX, PMAX, PMAX, NMAX);
      offer_matrix(NMAX, NMAX, PMAX, PMAX, NMAX, NMAX, NMAX, PMAX, PMAX);
      offer_matrix(PMAX, PMAX, NMAX, NMAX, PMAX, PMAX, PMAX, NMAX, PMAX);
      // Negative sums on individual lanes clamp to zero.
      offer_matrix(NMAX, 0, 0, 0, PMAX, 0, 0, 0, 0);
      offer_matrix(16'sd6000, 16'sd3, 16'sd3, 16'sd3, 16'sd6000, 16'sd3, 16'sd3, 16'sd3,
                   -16'sd30000);
      // Sums just around full scale, just above zero and at zero.
      offer_matrix(16'sd16383, 16'sd1, -16'sd1, -16'sd1, 16'sd16383, 16'sd1, 16'sd1,
                   -16'sd1, 16'sd16383);
      offer_matrix(-16'sd5461, 16'sd7, 16'sd7, -16'sd7, -16'sd5461, 16'sd7, -16'sd7,
                   -16'sd7, -16'sd5461);
      offer_matrix(-16'sd5462, 16'sd1, 16'sd2, 16'sd3, -16'sd5461, 16'sd4, 16'sd5,
                   16'sd6, -16'sd5461);

      for (n = 0; n < RANDOM_WORDS; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            // arbitrary bit patterns
            for (k = 0; k < 9; k++)
               e[k] = IN_W'($urandom);
         end else if (kind < 80) begin
            // signed permutation near a rotation, with small noise on every entry
            p0 = $urandom_range(0, 2);
            p1 = (p0 + 1 + $urandom_range(0, 1)) % 3;
            p2 = 3 - p0 - p1;
            for (k = 0; k < 9; k++) begin
               noise = int'($urandom_range(0, 1200)) - 600;
               e[k]  = IN_W'(noise);
            end
            e[p0]     = IN_W'(($urandom_range(0, 1) ? 16384 : -16384) + int'(e[p0]));
            e[3 + p1] = IN_W'(($urandom_range(0, 1) ? 16384 : -16384) + int'(e[3 + p1]));
            e[6 + p2] = IN_W'(($urandom_range(0, 1) ? 16384 : -16384) + int'(e[6 + p2]));
         end else begin
            // unit-range diagonal, off-diagonal pairs often equal so differences vanish
            for (k = 0; k < 9; k++)
               e[k] = IN_W'(int'($urandom_range(0, 32768)) - 16384);
            if ($urandom_range(0, 2) == 0) e[3] = e[1];
            if ($urandom_range(0, 2) == 0) e[6] = e[2];
            if ($urandom_range(0, 2) == 0) e[7] = e[5];
         end
         offer_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
      end
      req_chan_if.valid <= 1'b0;

      // Drain: wait for every predicted quaternion, then let the channels settle before the verdict.
      while (pending_words != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending_words == 0)
         $display("rotation_matrix_to_quaternion_unit verification clean");
      else
         $display("rotation_matrix_to_quaternion_unit verification failed");
      $finish;
   end

endmodule
